// File: sv/ccc_pkg.sv
// shared types, constants and calendar functions for the calendar clock counter
package ccc_pkg;

    // action codes of an input item
    localparam logic [2:0] ACT_MS_TICK  = 3'd0;
    localparam logic [2:0] ACT_SEC_TICK = 3'd1;
    localparam logic [2:0] ACT_SET_DATE = 3'd2;
    localparam logic [2:0] ACT_SET_TIME = 3'd3;
    localparam logic [2:0] ACT_SET_ALL  = 3'd4;

    // last value of each counter before it wraps
    localparam logic [9:0]  MS_LAST      = 10'd999;
    localparam logic [5:0]  SEC_LAST     = 6'd59;
    localparam logic [5:0]  MIN_LAST     = 6'd59;
    localparam logic [4:0]  HOUR_LAST_24 = 5'd23;
    localparam logic [4:0]  HOUR_LAST_12 = 5'd11;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [13:0] YEAR_LAST    = 14'd9999;
    localparam logic [2:0]  WDAY_LAST    = 3'd7;
    localparam logic        HALF_LAST    = 1'b1;

    // reset values
    localparam logic [13:0] YEAR_RST  = 14'd2000;
    localparam logic [3:0]  MONTH_RST = 4'd1;
    localparam logic [4:0]  DAY_RST   = 5'd1;
    localparam logic [2:0]  WDAY_RST  = 3'd6;

    // one result item: the full time after the step
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
        logic [2:0]  weekday;
        logic        pm_flag;
        logic        accepted;
    } result_t;

    // divisibility by 25: 1024 = -1 and 32 = 7 (mod 25), folded into a small value
    function automatic logic div_by_25(input logic [13:0] y);
        logic [8:0] t;
        logic       hit;
        t = {1'b0, y[9:5], 3'b000} - {4'b0, y[9:5]} + {4'b0, y[4:0]}
            + 9'd25 - {5'b0, y[13:10]};
        hit = 1'b0;
        for (int k = 0; k <= 10; k++) begin
            if (t == 9'(k * 25)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // gregorian leap rule: by 4 and not by 100, or by 400
    function automatic logic leap_year(input logic [13:0] y);
        logic d25;
        d25 = div_by_25(y);
        return (y[1:0] == 2'b00) && (!d25 || (y[3:0] == 4'b0000));
    endfunction

    // month length, 31 for months out of range
    function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:    d = leap_year(y) ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: sv/calendar_clock_counter.sv
// top level: calendar clock built as a carry chain of counter cells
// the result item of an accepted item is registered into the output buffer
// throughput: one item per cycle while in_stall is low; the carry ripples through the whole cell chain
// (millisecond to year) within the same cycle
// results pass a two-entry output buffer; in_stall rises only when both entries hold items
// reset: 2000-01-01 00:00:00.000, Saturday, AM, 24-hour mode, output buffer empty
module calendar_clock_counter (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [13:0] new_year,
    input  logic [3:0]  new_month,
    input  logic [4:0]  new_day,
    input  logic [4:0]  new_hour,
    input  logic [5:0]  new_minute,
    input  logic [5:0]  new_second,
    input  logic [9:0]  new_millisecond,
    input  logic [2:0]  new_weekday,
    input  logic        new_half_day,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [9:0]  millisecond,
    output logic [2:0]  weekday,
    output logic        pm_flag,
    output logic        accepted
);

    logic             mode_reg;
    logic             in_accept;
    logic             date_ok;
    logic             time_ok;
    logic             wday_ok;
    logic             acc;
    logic             ms_inc;
    logic             sec_inc;
    logic             set_date;
    logic             set_time;
    logic             set_all;
    logic [4:0]       hour_last;
    logic [4:0]       day_last;
    logic             day_inc;

    logic [9:0]  ms_q, ms_n;
    logic [5:0]  sec_q, sec_n;
    logic [5:0]  min_q, min_n;
    logic [4:0]  hour_q, hour_n;
    logic [4:0]  day_q, day_n;
    logic [3:0]  month_q, month_n;
    logic [13:0] year_q, year_n;
    logic [2:0]  wday_q, wday_n;
    logic        half_q, half_n;

    logic ms_c, sec_c, min_c, hour_c, day_c, month_c, year_c, wday_c, half_c;

    ccc_pkg::result_t res;
    ccc_pkg::result_t res_out;

    // hour mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    assign in_accept = in_valid && !in_stall;

    // validation of set requests
    assign date_ok = (new_year <= ccc_pkg::YEAR_LAST) && (new_month >= 4'd1)
                     && (new_month <= ccc_pkg::MONTH_LAST) && (new_day >= 5'd1)
                     && (new_day <= ccc_pkg::days_in(new_year, new_month));
    assign time_ok = (new_hour <= ccc_pkg::HOUR_LAST_24) && (new_minute <= ccc_pkg::MIN_LAST)
                     && (new_second <= ccc_pkg::SEC_LAST)
                     && (new_millisecond <= ccc_pkg::MS_LAST);
    assign wday_ok = (new_weekday >= 3'd1) && (new_weekday <= ccc_pkg::WDAY_LAST);

    // action decode
    always_comb
    begin
        case (action)
            ccc_pkg::ACT_MS_TICK:  acc = 1'b1;
            ccc_pkg::ACT_SEC_TICK: acc = 1'b1;
            ccc_pkg::ACT_SET_DATE: acc = date_ok;
            ccc_pkg::ACT_SET_TIME: acc = time_ok;
            ccc_pkg::ACT_SET_ALL:  acc = date_ok && time_ok && wday_ok;
            default:               acc = 1'b0;
        endcase
    end

    assign ms_inc   = in_accept && (action == ccc_pkg::ACT_MS_TICK);
    assign sec_inc  = (in_accept && (action == ccc_pkg::ACT_SEC_TICK)) || ms_c;
    assign set_all  = in_accept && acc && (action == ccc_pkg::ACT_SET_ALL);
    assign set_date = (in_accept && acc && (action == ccc_pkg::ACT_SET_DATE)) || set_all;
    assign set_time = (in_accept && acc && (action == ccc_pkg::ACT_SET_TIME)) || set_all;

    // limits that depend on mode and calendar
    assign hour_last = mode_reg ? ccc_pkg::HOUR_LAST_12 : ccc_pkg::HOUR_LAST_24;
    assign day_last  = ccc_pkg::days_in(year_q, month_q);
    assign day_inc   = mode_reg ? half_c : hour_c;

    // time-of-day cells
    ccc_cell #(.WIDTH(10), .RST_VAL(10'd0), .WRAP_VAL(10'd0)) u_ms (
        .clk(clk), .rst_n(rst_n), .inc(ms_inc), .last(ccc_pkg::MS_LAST),
        .load(set_time), .load_val(new_millisecond),
        .count(ms_q), .count_next(ms_n), .carry(ms_c)
    );

    ccc_cell #(.WIDTH(6), .RST_VAL(6'd0), .WRAP_VAL(6'd0)) u_sec (
        .clk(clk), .rst_n(rst_n), .inc(sec_inc), .last(ccc_pkg::SEC_LAST),
        .load(set_time), .load_val(new_second),
        .count(sec_q), .count_next(sec_n), .carry(sec_c)
    );

    ccc_cell #(.WIDTH(6), .RST_VAL(6'd0), .WRAP_VAL(6'd0)) u_min (
        .clk(clk), .rst_n(rst_n), .inc(sec_c), .last(ccc_pkg::MIN_LAST),
        .load(set_time), .load_val(new_minute),
        .count(min_q), .count_next(min_n), .carry(min_c)
    );

    ccc_cell #(.WIDTH(5), .RST_VAL(5'd0), .WRAP_VAL(5'd0)) u_hour (
        .clk(clk), .rst_n(rst_n), .inc(min_c), .last(hour_last),
        .load(set_time), .load_val(new_hour),
        .count(hour_q), .count_next(hour_n), .carry(hour_c)
    );

    // am/pm flag, carries on the pm-to-am flip
    ccc_cell #(.WIDTH(1), .RST_VAL(1'b0), .WRAP_VAL(1'b0)) u_half (
        .clk(clk), .rst_n(rst_n), .inc(hour_c && mode_reg), .last(ccc_pkg::HALF_LAST),
        .load(set_all), .load_val(new_half_day),
        .count(half_q), .count_next(half_n), .carry(half_c)
    );

    // calendar cells
    ccc_cell #(.WIDTH(3), .RST_VAL(ccc_pkg::WDAY_RST), .WRAP_VAL(3'd1)) u_wday (
        .clk(clk), .rst_n(rst_n), .inc(day_inc), .last(ccc_pkg::WDAY_LAST),
        .load(set_all), .load_val(new_weekday),
        .count(wday_q), .count_next(wday_n), .carry(wday_c)
    );

    ccc_cell #(.WIDTH(5), .RST_VAL(ccc_pkg::DAY_RST), .WRAP_VAL(5'd1)) u_day (
        .clk(clk), .rst_n(rst_n), .inc(day_inc), .last(day_last),
        .load(set_date), .load_val(new_day),
        .count(day_q), .count_next(day_n), .carry(day_c)
    );

    ccc_cell #(.WIDTH(4), .RST_VAL(ccc_pkg::MONTH_RST), .WRAP_VAL(4'd1)) u_month (
        .clk(clk), .rst_n(rst_n), .inc(day_c), .last(ccc_pkg::MONTH_LAST),
        .load(set_date), .load_val(new_month),
        .count(month_q), .count_next(month_n), .carry(month_c)
    );

    ccc_cell #(.WIDTH(14), .RST_VAL(ccc_pkg::YEAR_RST), .WRAP_VAL(14'd0)) u_year (
        .clk(clk), .rst_n(rst_n), .inc(month_c), .last(ccc_pkg::YEAR_LAST),
        .load(set_date), .load_val(new_year),
        .count(year_q), .count_next(year_n), .carry(year_c)
    );

    // result item: the state after this step
    always_comb
    begin
        res.year        = year_n;
        res.month       = month_n;
        res.day         = day_n;
        res.hour        = hour_n;
        res.minute      = min_n;
        res.second      = sec_n;
        res.millisecond = ms_n;
        res.weekday     = wday_n;
        res.pm_flag     = half_n;
        res.accepted    = acc;
    end

    ccc_out_buf u_out_buf (
        .clk(clk), .rst_n(rst_n), .push(in_accept), .push_data(res),
        .full(in_stall), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(res_out)
    );

    // output ports
    assign year        = res_out.year;
    assign month       = res_out.month;
    assign day         = res_out.day;
    assign hour        = res_out.hour;
    assign minute      = res_out.minute;
    assign second      = res_out.second;
    assign millisecond = res_out.millisecond;
    assign weekday     = res_out.weekday;
    assign pm_flag     = res_out.pm_flag;
    assign accepted    = res_out.accepted;

    // a full buffer always shows an item at the port
    a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result item pending");

    // an accepted item always leaves a result item behind
    a_accept_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted item produced no result item");

    // counters move only on an accepted item
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable({year_q, month_q, day_q, hour_q, min_q, sec_q, ms_q,
                                wday_q, half_q}))
        else $error("calendar state changed without an item");

    // calendar stays in range
    a_calendar_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_q >= 4'd1) && (month_q <= ccc_pkg::MONTH_LAST) && (day_q >= 5'd1)
        && (ms_q <= ccc_pkg::MS_LAST) && (year_q <= ccc_pkg::YEAR_LAST)
        && (hour_q <= ccc_pkg::HOUR_LAST_24) && (wday_q >= 3'd1))
        else $error("calendar counter out of range");

    // year and weekday cells wrap to their first value
    a_top_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (!year_c || (year_n == 14'd0)) && (!wday_c || (wday_n == 3'd1)))
        else $error("year or weekday wrapped to a wrong value");

endmodule

// File: sv/ccc_cell.sv
// one counter cell of the carry chain: loads on load, else increments on carry in and wraps after its last value
module ccc_cell #(
    parameter int                 WIDTH    = 6,
    parameter logic [WIDTH-1:0]   RST_VAL  = '0,
    parameter logic [WIDTH-1:0]   WRAP_VAL = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             inc,
    input  logic [WIDTH-1:0] last,
    input  logic             load,
    input  logic [WIDTH-1:0] load_val,
    output logic [WIDTH-1:0] count,
    output logic [WIDTH-1:0] count_next,
    output logic             carry
);

    logic [WIDTH-1:0] count_reg;

    // carry out when the increment passes the last value
    always_comb
    begin
        carry = inc && (count_reg >= last);
        if (load)
        begin
            count_next = load_val;
        end
        else if (carry)
        begin
            count_next = WRAP_VAL;
        end
        else if (inc)
        begin
            count_next = count_reg + WIDTH'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RST_VAL;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// File: sv/ccc_out_buf.sv
// two-entry output buffer for result items
module ccc_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ccc_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output ccc_pkg::result_t out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    ccc_pkg::result_t main_reg;
    ccc_pkg::result_t skid_reg;

    // main entry drives the port, skid entry catches an item while the port stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || !out_stall)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the calendar clock counter
`timescale 1ns / 1ps

module testbench;

    // action codes the block does not decode
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_ITEMS = 195;

    // one input item as presented on the input channel
    typedef struct {
        logic [2:0]  action;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
        logic [2:0]  weekday;
        logic        half_day;
    } clock_item_t;

    // running copy of the clock and calendar, plus the times still owed by the block
    class calendar_tracker;
        int yr, mon, dy, hr, mn, sc, msec, wday, half;
        bit twelve;
        int errors;
        ccc_pkg::result_t pending[$];

        function new();
            yr = 2000; mon = 1; dy = 1; hr = 0; mn = 0; sc = 0; msec = 0;
            wday = 6; half = 0; twelve = 0; errors = 0;
        endfunction

        function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int y, int m);
            case (m)
                2:       return is_leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        // day, weekday, month and year carry
        function void roll_day();
            dy++;
            wday = (wday >= 7) ? 1 : wday + 1;
            if (dy > month_days(yr, mon)) begin
                dy = 1;
                mon++;
                if (mon > 12) begin
                    mon = 1;
                    yr = (yr >= 9999) ? 0 : yr + 1;
                end
            end
        endfunction

        // one second step with carry into minutes, hours and the date
        function void second_carry();
            sc++;
            if (sc < 60) return;
            sc = 0;
            mn++;
            if (mn < 60) return;
            mn = 0;
            hr++;
            if (twelve) begin
                if (hr < 12) return;
                hr = 0;
                half ^= 1;
                // only the pm-to-am flip starts a new day
                if (half != 0) return;
            end
            else begin
                if (hr < 24) return;
                hr = 0;
            end
            roll_day();
        endfunction

        // apply one accepted item and queue the time it must produce
        function void note_item(clock_item_t it);
            ccc_pkg::result_t want;
            bit ok, date_good, time_good, set_date, set_time;
            date_good = (it.year <= 9999) && (it.month >= 1) && (it.month <= 12)
                        && (it.day >= 1)
                        && (int'(it.day) <= month_days(int'(it.year), int'(it.month)));
            time_good = (it.hour < 24) && (it.minute < 60) && (it.second < 60)
                        && (it.millisecond < 1000);
            ok = 0;
            case (it.action)
                ccc_pkg::ACT_MS_TICK:
                begin
                    msec++;
                    if (msec >= 1000) begin
                        msec = 0;
                        second_carry();
                    end
                    ok = 1;
                end
                ccc_pkg::ACT_SEC_TICK:
                begin
                    second_carry();
                    ok = 1;
                end
                ccc_pkg::ACT_SET_DATE, ccc_pkg::ACT_SET_TIME, ccc_pkg::ACT_SET_ALL:
                begin
                    set_date = (it.action != ccc_pkg::ACT_SET_TIME);
                    set_time = (it.action != ccc_pkg::ACT_SET_DATE);
                    ok = (!set_date || date_good) && (!set_time || time_good)
                         && (it.action != ccc_pkg::ACT_SET_ALL
                             || (it.weekday >= 1 && it.weekday <= 7));
                    if (ok) begin
                        if (set_date) begin
                            yr = int'(it.year); mon = int'(it.month); dy = int'(it.day);
                        end
                        if (set_time) begin
                            hr = int'(it.hour); mn = int'(it.minute);
                            sc = int'(it.second); msec = int'(it.millisecond);
                        end
                        if (it.action == ccc_pkg::ACT_SET_ALL) begin
                            wday = int'(it.weekday);
                            half = int'(it.half_day);
                        end
                    end
                end
                default: ok = 0;
            endcase
            want.year        = yr[13:0];
            want.month       = mon[3:0];
            want.day         = dy[4:0];
            want.hour        = hr[4:0];
            want.minute      = mn[5:0];
            want.second      = sc[5:0];
            want.millisecond = msec[9:0];
            want.weekday     = wday[2:0];
            want.pm_flag     = half[0];
            want.accepted    = ok;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // compare one delivered time with the oldest one owed
        function void check_result(ccc_pkg::result_t got);
            ccc_pkg::result_t want;
            if (pending.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("year", 16'(want.year), 16'(got.year));
            compare_field("month", 16'(want.month), 16'(got.month));
            compare_field("day", 16'(want.day), 16'(got.day));
            compare_field("hour", 16'(want.hour), 16'(got.hour));
            compare_field("minute", 16'(want.minute), 16'(got.minute));
            compare_field("second", 16'(want.second), 16'(got.second));
            compare_field("millisecond", 16'(want.millisecond), 16'(got.millisecond));
            compare_field("weekday", 16'(want.weekday), 16'(got.weekday));
            compare_field("pm_flag", 16'(want.pm_flag), 16'(got.pm_flag));
            compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [13:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
    logic [9:0]  new_millisecond;
    logic [2:0]  new_weekday;
    logic        new_half_day;
    logic        out_valid;
    logic        out_stall;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [2:0]  weekday;
    logic        pm_flag;
    logic        accepted;

    calendar_tracker tracker = new();
    int tx_idle_pct = 9;
    int rx_idle_pct = 56;
    int items_sent = 0;
    int cycle_count = 0;

    calendar_clock_counter dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: check each delivered item, stall at random
    initial
    begin
        ccc_pkg::result_t got;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got = {year, month, day, hour, minute, second, millisecond,
                       weekday, pm_flag, accepted};
                tracker.check_result(got);
            end
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    function automatic clock_item_t make_item(logic [2:0] act, int y, int mo, int d,
                                              int h, int mi, int s, int ms,
                                              int wd, int hd);
        clock_item_t it;
        it.action = act;
        it.year = y[13:0]; it.month = mo[3:0]; it.day = d[4:0];
        it.hour = h[4:0]; it.minute = mi[5:0]; it.second = s[5:0];
        it.millisecond = ms[9:0]; it.weekday = wd[2:0]; it.half_day = hd[0];
        return it;
    endfunction

    // present one item, hold it until taken, then idle at random
    task automatic send_item(clock_item_t it);
        in_valid <= 1'b1;
        action <= it.action;
        new_year <= it.year;
        new_month <= it.month;
        new_day <= it.day;
        new_hour <= it.hour;
        new_minute <= it.minute;
        new_second <= it.second;
        new_millisecond <= it.millisecond;
        new_weekday <= it.weekday;
        new_half_day <= it.half_day;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.note_item(it);
        if (it.action <= ccc_pkg::ACT_SET_ALL) items_sent++;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending and wait for every owed time to come back
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.twelve = m;
    endtask

    // 24-hour mode: leap rule, month and year ends, rejected sets, spare codes
    task automatic run_directed_24h();
        send_item(make_item(ccc_pkg::ACT_MS_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SEC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_ALL, 2000, 2, 28, 23, 59, 59, 999, 1, 0));
        send_item(make_item(ccc_pkg::ACT_MS_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 1900, 2, 29, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 0, 2, 29, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 2024, 2, 29, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_TIME, 0, 0, 0, 23, 59, 59, 500, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SEC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_ALL, 9999, 12, 31, 23, 59, 59, 999, 7, 1));
        send_item(make_item(ccc_pkg::ACT_MS_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // out-of-range dates and times, all-ones fields, bad weekday
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 16383, 15, 31, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 2023, 13, 1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 2023, 4, 31, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_DATE, 2023, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_TIME, 0, 0, 0, 24, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_TIME, 0, 0, 0, 31, 63, 63, 1023, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_TIME, 0, 0, 0, 0, 60, 59, 1000, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_ALL, 2023, 6, 15, 12, 0, 0, 0, 0, 1));
        send_item(make_item(ACT_SPARE_A, 2023, 6, 15, 12, 0, 0, 0, 3, 1));
        send_item(make_item(ACT_SPARE_B, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_SPARE_C, 16383, 15, 31, 31, 63, 63, 1023, 7, 1));
    endtask

    // 12-hour mode: am/pm flip, new day on pm-to-am, hour left above eleven
    task automatic run_directed_12h();
        send_item(make_item(ccc_pkg::ACT_SET_ALL, 2023, 12, 31, 11, 59, 59, 999, 7, 0));
        send_item(make_item(ccc_pkg::ACT_MS_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_TIME, 0, 0, 0, 11, 59, 59, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SEC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SET_TIME, 0, 0, 0, 23, 59, 59, 0, 0, 0));
        send_item(make_item(ccc_pkg::ACT_SEC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // random traffic: mostly sets just before a rollover followed by ticks
    task automatic run_random(int target);
        clock_item_t it;
        int stop_at, kind, y, mo, d, h, n;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                case ($urandom_range(0, 9))
                    0: y = 0;
                    1: y = 4;
                    2: y = 100;
                    3: y = 400;
                    4: y = 1900;
                    5: y = 2000;
                    6: y = 2100;
                    7: y = 9999;
                    8: y = 9996;
                    default: y = $urandom_range(0, 9999);
                endcase
                mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
                if ($urandom_range(0, 4) == 0)
                    d = $urandom_range(1, tracker.month_days(y, mo));
                else
                    d = tracker.month_days(y, mo) - $urandom_range(0, 1);
                case ($urandom_range(0, 3))
                    0: h = 23;
                    1: h = 11;
                    2: h = tracker.twelve ? 11 : 23;
                    default: h = $urandom_range(0, 23);
                endcase
                it = make_item(ccc_pkg::ACT_SET_ALL, y, mo, d, h, 59,
                               $urandom_range(58, 59), $urandom_range(990, 999),
                               $urandom_range(1, 7), $urandom_range(0, 1));
                if (kind >= 60) begin
                    // broken sequence: one value just out of range
                    case ($urandom_range(0, 5))
                        0: it.day = 5'(tracker.month_days(y, mo) + 1);
                        1: it.month = 4'd13;
                        2: it.hour = 5'd24;
                        3: it.minute = 6'd60;
                        4: it.millisecond = 10'd1000;
                        default: it.weekday = 3'd0;
                    endcase
                end
                if ($urandom_range(0, 3) == 0) begin
                    it.action = ccc_pkg::ACT_SET_DATE;
                    send_item(it);
                    it.action = ccc_pkg::ACT_SET_TIME;
                end
                send_item(it);
                n = $urandom_range(2, 14);
                repeat (n) begin
                    it.action = $urandom_range(0, 1) ? ccc_pkg::ACT_MS_TICK
                                                     : ccc_pkg::ACT_SEC_TICK;
                    send_item(it);
                end
            end
            else begin
                // noise: any code, fields anywhere in their width
                it = make_item(3'($urandom_range(0, 7)), $urandom_range(0, 16383),
                               $urandom_range(0, 15), $urandom_range(0, 31),
                               $urandom_range(0, 31), $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom_range(0, 1023),
                               $urandom_range(0, 7), $urandom_range(0, 1));
                send_item(it);
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid <= 1'b0;
        action <= ccc_pkg::ACT_MS_TICK;
        new_year <= '0;
        new_month <= '0;
        new_day <= '0;
        new_hour <= '0;
        new_minute <= '0;
        new_second <= '0;
        new_millisecond <= '0;
        new_weekday <= '0;
        new_half_day <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        run_directed_24h();
        drain();
        write_mode(1'b1);
        run_directed_12h();

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            tx_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 56 : 0;
            rx_idle_pct = (seg < 2) ? 56 : (seg < 4) ? 9 : 0;
            write_mode(seg[0]);
            run_random(SEGMENT_ITEMS);
        end

        drain();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
sv/ccc_pkg.sv
sv/ccc_cell.sv
sv/ccc_out_buf.sv
sv/calendar_clock_counter.sv
tb/sv/testbench.sv
